// File: rtl/core/rx_quality_tracker_unit_defines.svh
// assertion macros used by the checker of the quality tracker
`ifndef RX_QUALITY_TRACKER_UNIT_DEFINES_SVH
`define RX_QUALITY_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define RXQT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define RXQT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rxqt_pkg.sv
package rxqt_pkg;

	// field widths
	localparam int CMD_W   = 2;
	localparam int ERR_W   = 2;
	localparam int BITS_W  = 6;
	localparam int UPEN_W  = 8;
	localparam int APEN_W  = 8;
	localparam int PBITS_W = 16;
	localparam int FILL_W  = 16;
	localparam int TREND_W = 2;

	// percent in unsigned fixed point: integer part and fraction bits
	localparam int PCT_W  = 7;
	localparam int FRAC_W = 16;
	localparam int Q_W    = PCT_W + FRAC_W;

	// bucket counter widths
	localparam int BKT_W = 17;
	localparam int PEN_W = 32;

	// quality constants
	localparam logic [Q_W-1:0]    Q_FULL     = Q_W'(6553600);
	localparam logic [Q_W-1:0]    Q_RESET    = Q_W'(6520832);
	localparam logic [Q_W-1:0]    Q_HIGH     = Q_W'(6547047);
	localparam logic [Q_W-1:0]    Q_UNLOCK   = Q_W'(6540493);
	localparam logic [Q_W-1:0]    Q_BOOST    = Q_W'(6225920);
	localparam logic [PCT_W-1:0]  PCT_SCALE  = PCT_W'(100);
	localparam int                EMA_DIV    = 5;
	localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(10000);

	// command codes
	localparam logic [CMD_W-1:0] CMD_CODEWORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PENALTY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

	// trend codes
	localparam logic [TREND_W-1:0] TREND_FLAT = 2'd0;
	localparam logic [TREND_W-1:0] TREND_UP   = 2'd1;
	localparam logic [TREND_W-1:0] TREND_DOWN = 2'd2;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/core/rxqt_if.sv
// input item channel
interface rxqt_item_if import rxqt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [ERR_W-1:0]   err;
	logic               is_address;
	logic [BITS_W-1:0]  data_bits;
	logic [UPEN_W-1:0]  uncorrectable_penalty;
	logic [APEN_W-1:0]  address_penalty;
	logic [PBITS_W-1:0] penalty_bits;

	modport source (
		output valid, cmd, err, is_address, data_bits, uncorrectable_penalty,
			address_penalty, penalty_bits,
		input  ready
	);
	modport sink (
		input  valid, cmd, err, is_address, data_bits, uncorrectable_penalty,
			address_penalty, penalty_bits,
		output ready
	);
endinterface

// configuration write channel
interface rxqt_cfg_if import rxqt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FILL_W-1:0] bucket_fill_bits;

	modport source (output valid, bucket_fill_bits, input ready);
	modport sink (input valid, bucket_fill_bits, output ready);
endinterface

// result channel
interface rxqt_result_if import rxqt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [Q_W-1:0]     quality_ema;
	logic [TREND_W-1:0] trend;

	modport source (output valid, quality_ema, trend, input ready);
	modport sink (input valid, quality_ema, trend, output ready);
endinterface

// File: rtl/core/rxqt_div.sv
// restoring divider, one quotient bit per cycle
// the upper DEN_W bits of num must be below den
module rxqt_div import rxqt_pkg::*; #(
	parameter int DEN_W = 19,
	parameter int QUO_W = 23
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	output logic [QUO_W-1:0]       quot,
	output div_stat_t              stat
);
	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] work_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one trial subtract per cycle
	always_comb begin
		trial = {rem_q, work_q[QUO_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[DEN_W+QUO_W-1:QUO_W];
			work_q <= num[QUO_W-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_q <= {work_q[QUO_W-2:0], ge};
		end
	end

	assign quot      = work_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// File: rtl/core/rx_quality_tracker_unit.sv
// channel  | role   | payload
// ---------+--------+----------------------------------------------------
// item     | sink   | cmd, err, is_address, data_bits, penalties
// cfg      | sink   | bucket_fill_bits, always ready
// result   | source | quality_ema, trend (state after each item)
//
// codeword, penalty and clear items go through EXEC and DONE into the result register
// a tick sums one bucket per cycle, then runs up to two passes of the shared
// 23-step divider
// ready only while the sequencer is idle; the result register lets the
// next item enter while the previous result is still waiting
// reset is asynchronous and returns all buckets and the average to reset
module rx_quality_tracker_unit import rxqt_pkg::*; #(
	parameter int NUM_BUCKETS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	rxqt_item_if.sink      item,
	rxqt_cfg_if.sink       cfg,
	rxqt_result_if.source  result
);
	localparam int IDX_W   = $clog2(NUM_BUCKETS);
	localparam int TOT_W   = BKT_W + IDX_W;
	localparam int BAD_W   = PEN_W + 1 + IDX_W;
	localparam int DIV_N_W = TOT_W + Q_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_EXEC = 4'd1;
	localparam logic [3:0] ST_SUM  = 4'd2;
	localparam logic [3:0] ST_CALC = 4'd3;
	localparam logic [3:0] ST_DIVQ = 4'd4;
	localparam logic [3:0] ST_EMA  = 4'd5;
	localparam logic [3:0] ST_DIVE = 4'd6;
	localparam logic [3:0] ST_UPD  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q;

	// captured item
	logic [CMD_W-1:0]   cmd_q;
	logic [ERR_W-1:0]   err_q;
	logic               addr_q;
	logic [BITS_W-1:0]  bits_q;
	logic [UPEN_W-1:0]  upen_q;
	logic [APEN_W-1:0]  apen_q;
	logic [PBITS_W-1:0] pbits_q;

	// tracker state
	logic [FILL_W-1:0]  fill_q;
	logic [BKT_W-1:0]   tot_q [NUM_BUCKETS];
	logic [PEN_W-1:0]   pen_q [NUM_BUCKETS];
	logic [BKT_W-1:0]   unc_q [NUM_BUCKETS];
	logic [Q_W-1:0]     avg_q;
	logic [TREND_W-1:0] trend_q;

	// tick working registers
	logic [IDX_W-1:0] idx_q;
	logic [TOT_W-1:0] tot_acc_q;
	logic [BAD_W-1:0] bad_acc_q;
	logic [Q_W-1:0]   inst_q;
	logic [Q_W-1:0]   nq_q;

	// result register
	logic               out_valid_q;
	logic [Q_W-1:0]     out_quality_q;
	logic [TREND_W-1:0] out_trend_q;

	logic accept;
	logic out_free;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid       = out_valid_q;
	assign result.quality_ema = out_quality_q;
	assign result.trend       = out_trend_q;

	// codeword update of the newest bucket
	logic [Q_W-1:0]   avg_cw;
	logic [2:0]       eff_err;
	logic [BKT_W-1:0] tot0_cw;
	logic [BKT_W-1:0] unc0_cw;
	logic [UPEN_W:0]  pen_inc;
	logic [PEN_W:0]   pen_sum_cw;
	logic [PEN_W-1:0] pen0_cw;
	logic             shift;
	logic [BKT_W-1:0] cw_tot [NUM_BUCKETS];
	logic [PEN_W-1:0] cw_pen [NUM_BUCKETS];
	logic [BKT_W-1:0] cw_unc [NUM_BUCKETS];
	logic [BKT_W-1:0] nxt_tot [NUM_BUCKETS];
	logic [PEN_W-1:0] nxt_pen [NUM_BUCKETS];
	logic [BKT_W-1:0] nxt_unc [NUM_BUCKETS];

	always_comb begin
		avg_cw  = (err_q != '0 && avg_q >= Q_HIGH) ? Q_UNLOCK : avg_q;
		eff_err = (avg_cw > Q_BOOST) ? {err_q, 1'b0} : {1'b0, err_q};
		tot0_cw = tot_q[0] + BKT_W'(bits_q);
		unc0_cw = unc_q[0];
		pen_inc = '0;
		if (eff_err >= 3'd3) begin
			unc0_cw = unc_q[0] + BKT_W'(bits_q);
			pen_inc = (UPEN_W+1)'(upen_q) + (addr_q ? (UPEN_W+1)'(apen_q) : '0);
		end else if (eff_err != 3'd0) begin
			pen_inc = (UPEN_W+1)'({eff_err, 1'b0});
		end
		pen_sum_cw = {1'b0, pen_q[0]} + (PEN_W+1)'(pen_inc);
		pen0_cw    = pen_sum_cw[PEN_W] ? '1 : pen_sum_cw[PEN_W-1:0];
		shift      = (tot0_cw >= {1'b0, fill_q});
		for (int k = 0; k < NUM_BUCKETS; k++) begin
			cw_tot[k] = tot_q[k];
			cw_pen[k] = pen_q[k];
			cw_unc[k] = unc_q[k];
		end
		cw_tot[0] = tot0_cw;
		cw_pen[0] = pen0_cw;
		cw_unc[0] = unc0_cw;
		// slide toward the oldest bucket, halving the error counts
		for (int k = 0; k < NUM_BUCKETS; k++) begin
			if (!shift) begin
				nxt_tot[k] = cw_tot[k];
				nxt_pen[k] = cw_pen[k];
				nxt_unc[k] = cw_unc[k];
			end else if (k == 0) begin
				nxt_tot[k] = '0;
				nxt_pen[k] = '0;
				nxt_unc[k] = '0;
			end else begin
				nxt_tot[k] = cw_tot[k-1];
				nxt_pen[k] = cw_pen[k-1] >> 1;
				nxt_unc[k] = cw_unc[k-1] >> 1;
			end
		end
	end

	// extra penalty, clamped to the newest total
	logic [PBITS_W:0] pb;
	logic [PEN_W:0]   pen_sum_pb;
	logic [PEN_W-1:0] pen_sat_pb;
	logic [PEN_W-1:0] pen0_pb;

	always_comb begin
		pb         = (avg_q > Q_BOOST) ? {pbits_q, 1'b0} : {1'b0, pbits_q};
		pen_sum_pb = {1'b0, pen_q[0]} + (PEN_W+1)'(pb);
		pen_sat_pb = pen_sum_pb[PEN_W] ? '1 : pen_sum_pb[PEN_W-1:0];
		pen0_pb    = (pen_sat_pb > PEN_W'(tot_q[0])) ? PEN_W'(tot_q[0]) : pen_sat_pb;
	end

	// instant quality numerator and shared divider
	logic [TOT_W-1:0]       bad_cl;
	logic [TOT_W-1:0]       good;
	logic [TOT_W+PCT_W-1:0] good_x100;
	logic                   ema_recover;
	logic                   div_start;
	logic [DIV_N_W-1:0]     div_num;
	logic [TOT_W-1:0]       div_den;
	logic [Q_W-1:0]         div_quot;
	div_stat_t              div_stat;
	logic [Q_W-1:0]         nq_fin;
	logic [TREND_W-1:0]     trend_new;

	always_comb begin
		bad_cl = (bad_acc_q > BAD_W'(tot_acc_q)) ? tot_acc_q : bad_acc_q[TOT_W-1:0];
		good   = tot_acc_q - bad_cl;
		good_x100 = (TOT_W+PCT_W)'(good) * (TOT_W+PCT_W)'(PCT_SCALE);
		ema_recover = !(inst_q < avg_q);
		div_start = 1'b0;
		div_num   = {good_x100, {FRAC_W{1'b0}}};
		div_den   = tot_acc_q;
		if (state_q == ST_CALC) begin
			div_start = (tot_acc_q != '0);
		end else if (state_q == ST_EMA) begin
			div_start = ema_recover;
			div_num   = DIV_N_W'({avg_q, 2'b00}) + DIV_N_W'(inst_q);
			div_den   = TOT_W'(EMA_DIV);
		end
		nq_fin = (nq_q >= Q_HIGH) ? Q_FULL : nq_q;
		if (nq_fin > avg_q)
			trend_new = TREND_UP;
		else if (nq_fin < avg_q)
			trend_new = TREND_DOWN;
		else
			trend_new = TREND_FLAT;
	end

	rxqt_div #(
		.DEN_W (TOT_W),
		.QUO_W (Q_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= item.cmd;
			err_q   <= item.err;
			addr_q  <= item.is_address;
			bits_q  <= item.data_bits;
			upen_q  <= item.uncorrectable_penalty;
			apen_q  <= item.address_penalty;
			pbits_q <= item.penalty_bits;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			fill_q <= cfg.bucket_fill_bits;
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_q       <= Q_RESET;
			trend_q     <= TREND_FLAT;
			idx_q       <= '0;
			tot_acc_q   <= '0;
			bad_acc_q   <= '0;
			inst_q      <= '0;
			nq_q        <= '0;
			for (int k = 0; k < NUM_BUCKETS; k++) begin
				tot_q[k] <= '0;
				pen_q[k] <= '0;
				unc_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						tot_acc_q <= '0;
						bad_acc_q <= '0;
						state_q   <= (item.cmd == CMD_TICK) ? ST_SUM : ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_CODEWORD: begin
							avg_q <= avg_cw;
							for (int k = 0; k < NUM_BUCKETS; k++) begin
								tot_q[k] <= nxt_tot[k];
								pen_q[k] <= nxt_pen[k];
								unc_q[k] <= nxt_unc[k];
							end
						end
						CMD_PENALTY: begin
							pen_q[0] <= pen0_pb;
						end
						CMD_CLEAR: begin
							avg_q   <= Q_RESET;
							trend_q <= TREND_FLAT;
							for (int k = 0; k < NUM_BUCKETS; k++) begin
								tot_q[k] <= '0;
								pen_q[k] <= '0;
								unc_q[k] <= '0;
							end
						end
						default: begin
						end
					endcase
					state_q <= ST_DONE;
				end
				// one bucket per cycle into the sums
				ST_SUM: begin
					tot_acc_q <= tot_acc_q + TOT_W'(tot_q[idx_q]);
					bad_acc_q <= bad_acc_q + BAD_W'(pen_q[idx_q]) + BAD_W'(unc_q[idx_q]);
					if (idx_q == IDX_W'(NUM_BUCKETS - 1))
						state_q <= ST_CALC;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_CALC: begin
					if (tot_acc_q == '0) begin
						inst_q  <= Q_FULL;
						state_q <= ST_EMA;
					end else begin
						state_q <= ST_DIVQ;
					end
				end
				ST_DIVQ: begin
					if (div_stat.done) begin
						inst_q  <= div_quot;
						state_q <= ST_EMA;
					end
				end
				// drop at once, or recover through the divide by five
				ST_EMA: begin
					if (ema_recover) begin
						state_q <= ST_DIVE;
					end else begin
						nq_q    <= inst_q;
						state_q <= ST_UPD;
					end
				end
				ST_DIVE: begin
					if (div_stat.done) begin
						nq_q    <= div_quot;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					avg_q   <= nq_fin;
					trend_q <= trend_new;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.valid && result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_quality_q <= avg_q;
			out_trend_q   <= trend_q;
		end
	end
endmodule

// File: rtl/core/rxqt_checker.sv
`include "rx_quality_tracker_unit_defines.svh"

// port-level checks of the quality tracker
module rxqt_checker import rxqt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic [Q_W-1:0]     quality_ema,
	input logic [TREND_W-1:0] trend
);
	// stalled result holds
	`RXQT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(quality_ema) && $stable(trend), "result changed while stalled")

	// average never above full scale
	`RXQT_ASSERT_IMP(a_quality_range, result_valid, quality_ema <= Q_FULL, "quality above full scale")

	// the top band always snaps to full scale
	`RXQT_ASSERT_IMP(a_quality_band, result_valid, quality_ema < Q_HIGH || quality_ema == Q_FULL, "quality left in snap band")

	// busy in the cycle after a transfer
	`RXQT_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready right after a transfer")
endmodule

bind rx_quality_tracker_unit rxqt_checker u_rxqt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.quality_ema  (result.quality_ema),
	.trend        (result.trend)
);
